// ----- hdl/dmc_pkg.sv -----
// shared types and constants for the drive mode controller
package dmc_pkg;

  typedef enum logic [1:0] {
    MODE_FORWARD   = 2'd0,
    MODE_REVERSE   = 2'd1,
    MODE_BRAKE     = 2'd2,
    MODE_EMERGENCY = 2'd3
  } mode_t;

  // button codes
  localparam logic [1:0] BTN_EMERGENCY = 2'd0;
  localparam logic [1:0] BTN_FORWARD   = 2'd1;

  // item kinds
  localparam logic KIND_POLL  = 1'b0;
  localparam logic KIND_PRESS = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOCKOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_LIMIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_STEP    = 3'd6;

  localparam int unsigned CFG_DATA_W = 16;

  // reset values
  localparam logic [15:0] RST_PRESS_LOCKOUT = 16'd200;
  localparam logic [15:0] RST_RAMP_INTERVAL = 16'd10;
  localparam logic [11:0] RST_FORWARD_LEVEL = 12'd2000;
  localparam logic [11:0] RST_REVERSE_LIMIT = 12'd1000;
  localparam logic [11:0] RST_REVERSE_STEP  = 12'd5;
  localparam logic [9:0]  RST_SERVO_LIMIT   = 10'd500;
  localparam logic [9:0]  RST_SERVO_STEP    = 10'd2;
  localparam logic [9:0]  SERVO_PARK        = 10'd500;
  localparam logic [9:0]  SERVO_MAX         = 10'd1000;

  typedef struct packed {
    logic        kind;
    logic [1:0]  button;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    mode_t       mode;
    logic        forward_enable;
    logic        reverse_enable;
    logic [11:0] drive_level;
    logic [9:0]  servo_position;
  } out_t;

  typedef struct packed {
    logic [15:0] press_lockout_ms;
    logic [15:0] ramp_interval_ms;
    logic [11:0] forward_level;
    logic [11:0] reverse_limit;
    logic [11:0] reverse_step;
    logic [9:0]  brake_servo_limit;
    logic [9:0]  brake_servo_step;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] last_press;
    logic [31:0] last_ramp;
    logic [11:0] level;
    logic [9:0]  servo;
    logic        fwd_pin;
    logic        rev_pin;
  } state_t;

endpackage

// ----- hdl/dmc_step.sv -----
// next-state logic for one press or poll word
module dmc_step (
  input  dmc_pkg::state_t st,
  input  dmc_pkg::cfg_t   cfg,
  input  dmc_pkg::in_t    item,
  output dmc_pkg::state_t st_nxt
);

  logic [31:0] press_age;
  logic [31:0] ramp_age;
  logic        press_ok;
  logic        due;
  logic [12:0] level_sum;
  logic [10:0] servo_sum;

  assign press_age = item.now_ms - st.last_press;
  assign ramp_age  = item.now_ms - st.last_ramp;
  assign press_ok  = press_age >= {16'd0, cfg.press_lockout_ms};
  assign due       = ramp_age >= {16'd0, cfg.ramp_interval_ms};
  assign level_sum = {1'b0, st.level} + {1'b0, cfg.reverse_step};
  assign servo_sum = {1'b0, st.servo} + {1'b0, cfg.brake_servo_step};

  always_comb begin
    st_nxt = st;
    if (item.kind == dmc_pkg::KIND_PRESS) begin
      if (press_ok) begin
        if (item.button == dmc_pkg::BTN_EMERGENCY) begin
          st_nxt.mode       = dmc_pkg::MODE_EMERGENCY;
          st_nxt.last_press = item.now_ms;
        end else if (st.mode != dmc_pkg::MODE_EMERGENCY) begin
          // buttons 1..3 map onto modes 0..2
          st_nxt.mode       = dmc_pkg::mode_t'(item.button - dmc_pkg::BTN_FORWARD);
          st_nxt.last_press = item.now_ms;
        end
      end
    end else begin
      unique case (st.mode)
        dmc_pkg::MODE_FORWARD: begin
          st_nxt.fwd_pin = 1'b1;
          st_nxt.rev_pin = 1'b0;
          st_nxt.level   = cfg.forward_level;
        end
        dmc_pkg::MODE_REVERSE: begin
          st_nxt.fwd_pin = 1'b0;
          st_nxt.rev_pin = 1'b1;
          if (due) begin
            if (st.level < cfg.reverse_limit) begin
              st_nxt.level = (level_sum > {1'b0, cfg.reverse_limit}) ?
                             cfg.reverse_limit : level_sum[11:0];
            end
            st_nxt.last_ramp = item.now_ms;
          end
        end
        dmc_pkg::MODE_BRAKE: begin
          st_nxt.fwd_pin = 1'b0;
          st_nxt.rev_pin = 1'b0;
          st_nxt.level   = 12'd0;
          if (due) begin
            if (st.servo < cfg.brake_servo_limit) begin
              st_nxt.servo = (servo_sum > {1'b0, dmc_pkg::SERVO_MAX}) ?
                             dmc_pkg::SERVO_MAX : servo_sum[9:0];
            end
            st_nxt.last_ramp = item.now_ms;
          end
        end
        default: begin
          st_nxt.fwd_pin = 1'b0;
          st_nxt.rev_pin = 1'b0;
          st_nxt.level   = 12'd0;
          st_nxt.servo   = 10'd0;
        end
      endcase
    end
  end

endmodule

// ----- hdl/drive_mode_controller_with_ramps.sv -----
// top level of the four-mode drive controller with reverse and brake ramps
//
// usage:
//   in_*   : one word per button press (kind 1) or poll (kind 0), each with a
//            millisecond timestamp; valid/ready handshake
//   out_*  : one result word per input word, in order: mode, direction pins,
//            drive level and servo position after that word
//   cfg_*  : register writes (index 0..6, data in low bits), always ready;
//            write only while the block is idle, indexes past 6 are dropped
// latency: 1 cycle from input accept to result valid (the input register
//   takes the word at the accept edge, the result register one edge later)
// throughput: one word per cycle; the rate is set by the single state update
//   pass between the input register and the result register
// reset: synchronous active-low rst_n empties both stages, restores the
//   register defaults, puts the mode to forward, level 0, servo parked at 500
// stall: when out_ready is low the result holds, the input register keeps
//   its word and in_ready drops once both stages are full; no word is lost
module drive_mode_controller_with_ramps (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dmc_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dmc_pkg::out_t                       out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dmc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dmc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  dmc_pkg::cfg_t   cfg_r;
  dmc_pkg::state_t st_r;
  dmc_pkg::state_t st_nxt;
  dmc_pkg::in_t    in_word_r;
  logic            in_valid_r;
  dmc_pkg::out_t   out_word_r;
  logic            out_valid_r;
  logic            advance;

  // the held word moves on when the result slot is free or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  dmc_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (in_word_r),
    .st_nxt (st_nxt)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_lockout_ms  <= dmc_pkg::RST_PRESS_LOCKOUT;
      cfg_r.ramp_interval_ms  <= dmc_pkg::RST_RAMP_INTERVAL;
      cfg_r.forward_level     <= dmc_pkg::RST_FORWARD_LEVEL;
      cfg_r.reverse_limit     <= dmc_pkg::RST_REVERSE_LIMIT;
      cfg_r.reverse_step      <= dmc_pkg::RST_REVERSE_STEP;
      cfg_r.brake_servo_limit <= dmc_pkg::RST_SERVO_LIMIT;
      cfg_r.brake_servo_step  <= dmc_pkg::RST_SERVO_STEP;
    end else if (cfg_valid) begin
      // values are truncated to the register width
      unique case (cfg_index)
        dmc_pkg::REG_PRESS_LOCKOUT: cfg_r.press_lockout_ms  <= cfg_data;
        dmc_pkg::REG_RAMP_INTERVAL: cfg_r.ramp_interval_ms  <= cfg_data;
        dmc_pkg::REG_FORWARD_LEVEL: cfg_r.forward_level     <= cfg_data[11:0];
        dmc_pkg::REG_REVERSE_LIMIT: cfg_r.reverse_limit     <= cfg_data[11:0];
        dmc_pkg::REG_REVERSE_STEP:  cfg_r.reverse_step      <= cfg_data[11:0];
        dmc_pkg::REG_SERVO_LIMIT:   cfg_r.brake_servo_limit <= cfg_data[9:0];
        dmc_pkg::REG_SERVO_STEP:    cfg_r.brake_servo_step  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_word_r <= in_data;
    end
  end

  // controller state, updated once per word as it moves to the result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode       <= dmc_pkg::MODE_FORWARD;
      st_r.last_press <= 32'd0;
      st_r.last_ramp  <= 32'd0;
      st_r.level      <= 12'd0;
      st_r.servo      <= dmc_pkg::SERVO_PARK;
      st_r.fwd_pin    <= 1'b0;
      st_r.rev_pin    <= 1'b0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r.mode           <= st_nxt.mode;
      out_word_r.forward_enable <= st_nxt.fwd_pin;
      out_word_r.reverse_enable <= st_nxt.rev_pin;
      out_word_r.drive_level    <= st_nxt.level;
      out_word_r.servo_position <= st_nxt.servo;
    end
  end

endmodule
